### hw/rtl/swmd_pkg.sv
// Shared constants and controller/datapath handshake types for the
// sliding window median deviation unit. No dependencies.
`timescale 1ns / 1ps
package swmd_pkg;
  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int IDX_BITS    = $clog2(MAX_WINDOW);
  localparam int CNT_BITS    = $clog2(MAX_WINDOW + 1);
  localparam int SUM_BITS    = SAMPLE_BITS + IDX_BITS;
  localparam int COST_BITS   = SUM_BITS + 1;
  localparam int CFG_BITS    = 7;
  localparam logic [CFG_BITS-1:0] WINDOW_RESET = CFG_BITS'(3);

  typedef struct packed {
    logic accept;
    logic decide;
    logic evict;
    logic insert;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic emit;
    logic out_busy;
  } status_t;
endpackage

### hw/rtl/swmd_if.sv
// Valid/ready channel interfaces for sample requests and cost results.
// Depends on swmd_pkg.
`timescale 1ns / 1ps
interface swmd_sample_if;
  logic valid;
  logic ready;
  logic signed [swmd_pkg::SAMPLE_BITS-1:0] sample;
  logic restart;
  modport source (output valid, output sample, output restart, input ready);
  modport sink (input valid, input sample, input restart, output ready);
endinterface

interface swmd_cost_if;
  logic valid;
  logic ready;
  logic [swmd_pkg::COST_BITS-1:0] cost;
  modport source (output valid, output cost, input ready);
  modport sink (input valid, input cost, output ready);
endinterface

### hw/rtl/swmd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module swmd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/swmd_ctrl.sv
// Sequencer for one sample request: decide, evict, insert, deliver.
// Depends on swmd_pkg.
`timescale 1ns / 1ps
module swmd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  swmd_pkg::status_t status,
  output swmd_pkg::cmd_t    cmd
);
  typedef enum logic [2:0] {IDLE, DECIDE, EVICT, INSERT, FINISH} state_t;
  state_t state;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      IDLE:    cmd.accept = in_valid;
      DECIDE:  cmd.decide = 1'b1;
      EVICT:   cmd.evict  = 1'b1;
      INSERT:  cmd.insert = 1'b1;
      FINISH:  cmd.load   = status.emit && !status.out_busy;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE:    if (in_valid) state <= DECIDE;
        DECIDE:  state <= status.full ? EVICT : INSERT;
        EVICT:   state <= INSERT;
        INSERT:  state <= FINISH;
        FINISH:  if (!status.emit || !status.out_busy) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end
endmodule

### hw/rtl/swmd_datapath.sv
// Arrival ring, sorted cell chain, half sums and output register.
// Depends on swmd_pkg and swmd_ram.
`timescale 1ns / 1ps
module swmd_datapath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  swmd_pkg::cmd_t                          cmd,
  output swmd_pkg::status_t                       status,
  input  logic signed [swmd_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                    in_restart,
  input  logic                                    cfg_we,
  input  logic [swmd_pkg::CFG_BITS-1:0]           cfg_data,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [swmd_pkg::COST_BITS-1:0]          out_cost
);
  localparam int W  = swmd_pkg::SAMPLE_BITS;
  localparam int N  = swmd_pkg::MAX_WINDOW;
  localparam int IB = swmd_pkg::IDX_BITS;
  localparam int CB = swmd_pkg::CNT_BITS;
  localparam int SB = swmd_pkg::SUM_BITS;
  localparam int OB = swmd_pkg::COST_BITS;

  logic [swmd_pkg::CFG_BITS-1:0] window_size;
  logic [CB-1:0] count, size_eff;
  logic [IB-1:0] ptr, mid, mid1;
  logic signed [W-1:0] s;
  logic signed [W-1:0] cells [N];
  logic signed [SB-1:0] lower_sum, total_sum;
  logic was_full, emit;
  logic [W-1:0] ring_rdata;
  logic signed [W-1:0] r;
  logic [N-1:0] above, rm;
  logic signed [W-1:0] mid_cell, mid1_cell;
  logic signed [OB:0] cost_full;

  always_comb begin
    if (window_size == '0) begin
      size_eff = CB'(1);
    end else if (window_size > swmd_pkg::CFG_BITS'(N)) begin
      size_eff = CB'(N);
    end else begin
      size_eff = CB'(window_size);
    end
  end
  assign mid       = IB'((size_eff - CB'(1)) >> 1);
  assign mid1      = mid + IB'(1);
  assign mid_cell  = cells[mid];
  assign mid1_cell = cells[mid1];
  assign r         = $signed(ring_rdata);

  // The chain stays sorted, so both flag vectors are suffixes of the chain.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      above[i] = !((CB'(i) < count) && (cells[i] <= s));
      rm[i]    = !(cells[i] < r);
    end
  end

  assign cost_full = (OB+1)'(total_sum) - ((OB+1)'(lower_sum) <<< 1)
                   + (size_eff[0] ? (OB+1)'(mid_cell) : '0);

  swmd_ram #(.WIDTH(W), .DEPTH(N)) ring (
    .clk   (clk),
    .we    (cmd.evict || (cmd.insert && !was_full)),
    .waddr (cmd.evict ? ptr : count[IB-1:0]),
    .wdata (s),
    .raddr (ptr),
    .rdata (ring_rdata)
  );

  assign status.full     = (count == size_eff);
  assign status.emit     = emit;
  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swmd_pkg::WINDOW_RESET;
      count       <= '0;
      ptr         <= '0;
      lower_sum   <= '0;
      total_sum   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_size <= cfg_data;
      end
      if (cfg_we || (cmd.accept && in_restart)) begin
        count     <= '0;
        ptr       <= '0;
        lower_sum <= '0;
        total_sum <= '0;
      end
      if (cmd.accept) begin
        s <= in_sample;
      end
      if (cmd.decide) begin
        was_full <= status.full;
      end
      if (cmd.evict) begin
        for (int i = 0; i < N - 1; i++) begin
          if (rm[i]) cells[i] <= cells[i+1];
        end
        if (rm[mid]) begin
          lower_sum <= lower_sum - SB'(r)
                     + (((CB'(mid) + CB'(1)) < count) ? SB'(mid1_cell) : '0);
        end
        total_sum <= total_sum - SB'(r);
        count     <= count - CB'(1);
        ptr       <= ((CB'(ptr) + CB'(1)) == size_eff) ? '0 : ptr + IB'(1);
      end
      if (cmd.insert) begin
        for (int i = 0; i < N; i++) begin
          if (above[i]) begin
            if (i == 0) begin
              cells[i] <= s;
            end else begin
              cells[i] <= above[i-1] ? cells[i-1] : s;
            end
          end
        end
        if (above[mid]) begin
          lower_sum <= lower_sum + SB'(s)
                     - ((CB'(mid) < count) ? SB'(mid_cell) : '0);
        end
        total_sum <= total_sum + SB'(s);
        count     <= count + CB'(1);
        emit      <= ((count + CB'(1)) == size_eff);
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
        out_cost  <= cost_full[OB-1:0];
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

### hw/rtl/sliding_window_median_deviation_unit.sv
// Top level of the sliding window median deviation unit.
// Depends on swmd_pkg, swmd_if, swmd_ctrl and swmd_datapath.
`timescale 1ns / 1ps
// Each sample request passes through the decide, insert and finish states,
// with an evict state before insert once the window is full (it removes the
// oldest sample, read from the arrival ring RAM, from the sorted cell chain),
// and waits in finish while the previous cost has not been taken. A cost is
// delivered for every request that leaves the window full. Writing
// window_size empties the window, as does a request with restart set.
module sliding_window_median_deviation_unit (
  input  logic                              clk,
  input  logic                              rst,
  swmd_sample_if.sink                       in_ch,
  swmd_cost_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [swmd_pkg::CFG_BITS-1:0]     cfg_data
);
  swmd_pkg::cmd_t    cmd;
  swmd_pkg::status_t status;

  swmd_ctrl ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  swmd_datapath dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_sample  (in_ch.sample),
    .in_restart (in_ch.restart),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_cost   (out_ch.cost)
  );
endmodule

### tb/tb_sliding_window_median_deviation_unit.sv
// Self-checking testbench for the sliding window median deviation unit.
// Depends on swmd_pkg, swmd_if and the unit's RTL.
`timescale 1ns / 1ps
module tb_sliding_window_median_deviation_unit;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [swmd_pkg::CFG_BITS-1:0] cfg_data = '0;

  swmd_sample_if in_ch ();
  swmd_cost_if out_ch ();

  sliding_window_median_deviation_unit i_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Mirror of the window held by the unit.
  longint win_ring [swmd_pkg::MAX_WINDOW];
  int unsigned win_fill;
  int unsigned win_oldest;
  logic [swmd_pkg::CFG_BITS-1:0] win_size_reg;

  logic [swmd_pkg::COST_BITS-1:0] cost_expected [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.restart = 1'b0;
    out_ch.ready = 1'b0;
  end

  function automatic int unsigned active_size(logic [swmd_pkg::CFG_BITS-1:0] v);
    if (v == 0) return 1;
    if (v > swmd_pkg::MAX_WINDOW) return swmd_pkg::MAX_WINDOW;
    return 32'(v);
  endfunction

  function automatic logic [swmd_pkg::COST_BITS-1:0] deviation_sum(int unsigned n);
    longint sorted [swmd_pkg::MAX_WINDOW];
    longint key;
    longint lo_sum;
    longint hi_sum;
    longint c;
    int j;
    int mid;
    lo_sum = 0;
    hi_sum = 0;
    for (int i = 0; i < n; i++) sorted[i] = win_ring[i];
    for (int i = 1; i < n; i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    mid = (n - 1) / 2;
    for (int i = 0; i < n; i++) begin
      if (i <= mid) lo_sum += sorted[i];
      else hi_sum += sorted[i];
    end
    c = hi_sum - lo_sum + ((n % 2 == 1) ? sorted[mid] : 0);
    return c[swmd_pkg::COST_BITS-1:0];
  endfunction

  // Advances the mirror by one accepted request; returns 1 when a cost is due.
  function automatic bit window_advance(logic signed [swmd_pkg::SAMPLE_BITS-1:0] s,
                                        logic r,
                                        output logic [swmd_pkg::COST_BITS-1:0] cost);
    int unsigned n;
    n = active_size(win_size_reg);
    cost = '0;
    if (r) begin
      win_fill = 0;
      win_oldest = 0;
    end
    if (win_fill < n) begin
      win_ring[win_fill] = longint'(s);
      win_fill++;
      win_oldest = 0;
      if (win_fill < n) return 1'b0;
    end else begin
      win_ring[win_oldest] = longint'(s);
      win_oldest = (win_oldest + 1) % n;
    end
    cost = deviation_sum(n);
    return 1'b1;
  endfunction

  task automatic send_sample(logic signed [swmd_pkg::SAMPLE_BITS-1:0] s, logic r,
                             bit typed, logic [swmd_pkg::COST_BITS-1:0] typed_cost);
    logic [swmd_pkg::COST_BITS-1:0] c;
    bit due;
    if (burst_left == 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.sample = s;
    in_ch.restart = r;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    due = window_advance(s, r, c);
    if (due) cost_expected = {cost_expected, (typed ? typed_cost : c)};
  endtask

  // Writes the window size once the unit has drained.
  task automatic set_window(logic [swmd_pkg::CFG_BITS-1:0] v);
    @(negedge clk);
    in_ch.valid = 1'b0;
    burst_left = 0;
    wait (cost_expected.size() == 0);
    repeat (12) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    win_size_reg = v;
    win_fill = 0;
    win_oldest = 0;
  endtask

  function automatic logic [swmd_pkg::SAMPLE_BITS-1:0] random_sample(int unsigned style);
    case (style)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return swmd_pkg::SAMPLE_BITS'($signed($urandom_range(0, 20)) - 10);
      3: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stall patterns, plus one long hold to back up the input.
  initial begin
    int unsigned hold_left;
    int unsigned mode;
    int unsigned mode_left;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      cycle_count++;
      if (cycle_count == 1500) hold_left = 400;
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = ($urandom_range(0, 3) != 0);
          2: out_ch.ready = ($urandom_range(0, 3) == 0);
          default: out_ch.ready = cycle_count[2];
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (cost_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected cost %0d", out_ch.cost);
      end else begin
        if (out_ch.cost !== cost_expected[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cost mismatch: expected %0d, got %0d", cost_expected[0], out_ch.cost);
        end
        void'(cost_expected.pop_front());
      end
    end
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  typedef struct {
    bit write;
    logic [swmd_pkg::CFG_BITS-1:0] size;
    logic [swmd_pkg::SAMPLE_BITS-1:0] s;
    logic r;
    bit typed;
    logic [swmd_pkg::COST_BITS-1:0] c;
  } dir_row_t;

  localparam logic [swmd_pkg::SAMPLE_BITS-1:0] SMIN = 32'h8000_0000;
  localparam logic [swmd_pkg::SAMPLE_BITS-1:0] SMAX = 32'h7FFF_FFFF;
  localparam logic [swmd_pkg::COST_BITS-1:0] SPAN = 39'hFFFF_FFFF;

  dir_row_t dir_rows [] = '{
    '{0, 0, SMIN, 0, 0, 0},
    '{0, 0, SMAX, 0, 0, 0},
    '{0, 0, 0, 0, 1, SPAN},
    '{0, 0, SMIN, 0, 0, 0},
    '{0, 0, 0, 1, 0, 0},
    '{0, 0, 32'hFFFF_FFFF, 1, 0, 0},
    '{0, 0, 5, 0, 0, 0},
    '{0, 0, 7, 0, 0, 0},
    '{0, 0, SMIN, 0, 0, 0},
    '{1, 1, 0, 0, 0, 0},
    '{0, 0, SMAX, 0, 1, 0},
    '{0, 0, SMIN, 1, 1, 0},
    '{1, 2, 0, 0, 0, 0},
    '{0, 0, SMIN, 0, 0, 0},
    '{0, 0, SMAX, 0, 1, SPAN},
    '{0, 0, SMAX, 0, 0, 0},
    '{1, 0, 0, 0, 0, 0},
    '{0, 0, 12345, 0, 1, 0},
    '{0, 0, SMIN, 0, 1, 0},
    '{1, 127, 0, 0, 0, 0},
    '{0, 0, 1, 0, 0, 0}
  };

  logic [swmd_pkg::CFG_BITS-1:0] phase_sizes [] =
    '{3, 1, 2, 64, 0, 127, 5, 8, 17, 33, 100, 4, 9};

  initial begin
    int unsigned per_phase;
    win_size_reg = swmd_pkg::WINDOW_RESET;
    win_fill = 0;
    win_oldest = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].write) set_window(dir_rows[i].size);
      else send_sample(dir_rows[i].s, dir_rows[i].r, dir_rows[i].typed, dir_rows[i].c);
    end

    foreach (phase_sizes[p]) begin
      set_window(phase_sizes[p]);
      per_phase = (active_size(phase_sizes[p]) == swmd_pkg::MAX_WINDOW) ? 130 : 50;
      for (int k = 0; k < per_phase; k++)
        send_sample(random_sample($urandom_range(0, 9)), ($urandom_range(0, 39) == 0), 0, 0);
    end
    set_window(swmd_pkg::CFG_BITS'($urandom_range(1, 12)));
    for (int k = 0; k < 60; k++)
      send_sample(random_sample($urandom_range(0, 9)), ($urandom_range(0, 39) == 0), 0, 0);

    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (cost_expected.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

### sliding_window_median_deviation_unit.f
hw/rtl/swmd_pkg.sv
hw/rtl/swmd_if.sv
hw/rtl/swmd_ram.sv
hw/rtl/swmd_ctrl.sv
hw/rtl/swmd_datapath.sv
hw/rtl/sliding_window_median_deviation_unit.sv
tb/tb_sliding_window_median_deviation_unit.sv
